// ===== hdl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked during reset too
`define ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== hdl/twtt_pkg.sv =====
package twtt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int EXP_W = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] SLOTS_RESET = 8'd60;

   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_REFRESH = 2'd1;
   localparam logic [1:0] ACT_CANCEL  = 2'd2;
   localparam logic [1:0] ACT_TICK    = 2'd3;

   localparam logic [2:0] RES_DONE      = 3'd0;
   localparam logic [2:0] RES_FIRED     = 3'd1;
   localparam logic [2:0] RES_CANCELED  = 3'd2;
   localparam logic [2:0] RES_NOT_FOUND = 3'd3;
   localparam logic [2:0] RES_FULL      = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] timer_id;
      logic [7:0]  delay;
   } req_type;

   typedef struct packed {
      logic [31:0] event_id;
      logic [2:0]  event_res;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ident;
      logic [7:0]  period;
      logic [7:0]  remain;
   } entry_type;

endpackage

// ===== hdl/twtt_mod_unit.sv =====
module twtt_mod_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] dividend,
   input  logic [7:0] divisor,
   output logic [7:0] remainder
);
   import twtt_pkg::*;

   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] rem_ff, rem_in;
   logic [8:0] trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, shift_ff[7]};
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         cnt_in   = 4'd8;
         shift_in = dividend;
         rem_in   = 8'd0;
      end else if (cnt_ff != 4'd0) begin
         cnt_in   = cnt_ff - 4'd1;
         shift_in = {shift_ff[6:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = 8'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

// ===== hdl/timing_wheel_timer_table_top.sv =====
// results: a request's single result, and a tick's last result, is registered in ST_FINISH after
//   the walk over all TABLE_ENTRIES entries; earlier tick results leave mid-walk
// requests: a new item is taken only in ST_IDLE, after the walk over the entry memory (one entry
//   per cycle while not stalled) and ST_FINISH; any item waits further while the result register is held
// reset: synchronous, active high; clears valid and cancel bits, control and wheel_slots
//   (to 60); entry memory contents are not cleared
module timing_wheel_timer_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  twtt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output twtt_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);
   import twtt_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]               state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [7:0]               slots_ff, slots_in;
   logic [CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         proc_idx_ff, proc_idx_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         match_idx_ff, match_idx_in;
   logic [7:0]               match_period_ff, match_period_in;
   logic [7:0]               match_remain_ff, match_remain_in;
   logic                     hold_valid_ff, hold_valid_in;
   logic [31:0]              hold_id_ff, hold_id_in;
   logic [2:0]               hold_res_ff, hold_res_in;
   logic [EXP_W-1:0]         exp_cnt_ff, exp_cnt_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] cancel_ff, cancel_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   entry_type                mem [TABLE_ENTRIES];
   entry_type                rd_data_ff;
   logic                     rd_en;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_idx;
   entry_type                wr_data;

   logic                     mod_start;
   logic [7:0]               mod_rem;
   logic [7:0]               slots_eff;
   logic [7:0]               delay_eff;
   logic                     out_free;
   logic                     is_tick;
   logic                     cur_valid;
   logic [7:0]               new_rem;
   logic                     expire;
   logic                     stall;
   logic                     free_found;
   logic [IDX_W-1:0]         free_idx;
   logic [IDX_W-1:0]         tgt_idx;

   assign slots_eff = (slots_ff == 8'd0) ? 8'd1 : slots_ff;
   assign delay_eff = (mod_rem == 8'd0) ? slots_eff : mod_rem;

   twtt_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_data.delay),
      .divisor   (slots_eff),
      .remainder (mod_rem)
   );

   // lowest free entry
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(k);
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_tick   = (req_ff.action == ACT_TICK);
   assign cur_valid = valid_ff[proc_idx_ff];
   assign new_rem   = (rd_data_ff.remain == 8'd0) ? 8'd0 : rd_data_ff.remain - 8'd1;
   assign expire    = is_tick && pend_ff && cur_valid && (new_rem == 8'd0) &&
                      (exp_cnt_ff < EXP_W'(MAX_RESULTS));
   // a second expiry pushes the held one out, which needs the result register
   assign stall     = expire && hold_valid_ff && !out_free;
   assign tgt_idx   = found_ff ? match_idx_ff : free_idx;

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      slots_in        = csr_wr_en ? csr_wr_data : slots_ff;
      rd_idx_in       = rd_idx_ff;
      pend_in         = pend_ff;
      proc_idx_in     = proc_idx_ff;
      found_in        = found_ff;
      match_idx_in    = match_idx_ff;
      match_period_in = match_period_ff;
      match_remain_in = match_remain_ff;
      hold_valid_in   = hold_valid_ff;
      hold_id_in      = hold_id_ff;
      hold_res_in     = hold_res_ff;
      exp_cnt_in      = exp_cnt_ff;
      valid_in        = valid_ff;
      cancel_in       = cancel_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;
      rd_en           = 1'b0;
      wr_en           = 1'b0;
      wr_idx          = proc_idx_ff;
      wr_data         = rd_data_ff;
      mod_start       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               state_in      = ST_SCAN;
               rd_idx_in     = '0;
               pend_in       = 1'b0;
               found_in      = 1'b0;
               hold_valid_in = 1'b0;
               exp_cnt_in    = '0;
               mod_start     = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (pend_ff) begin
                  if (is_tick) begin
                     if (cur_valid) begin
                        wr_en          = 1'b1;
                        wr_data.remain = new_rem;
                        if (expire) begin
                           if (hold_valid_ff) begin
                              rsp_valid_in = 1'b1;
                              rsp_in       = '{event_id: hold_id_ff, event_res: hold_res_ff,
                                               last: 1'b0};
                           end
                           hold_valid_in          = 1'b1;
                           hold_id_in             = rd_data_ff.ident;
                           hold_res_in            = cancel_ff[proc_idx_ff] ? RES_CANCELED
                                                                           : RES_FIRED;
                           valid_in[proc_idx_ff]  = 1'b0;
                           cancel_in[proc_idx_ff] = 1'b0;
                           exp_cnt_in             = exp_cnt_ff + EXP_W'(1);
                        end
                     end
                  end else if (cur_valid && !found_ff &&
                               rd_data_ff.ident == req_ff.timer_id) begin
                     found_in        = 1'b1;
                     match_idx_in    = proc_idx_ff;
                     match_period_in = rd_data_ff.period;
                     match_remain_in = rd_data_ff.remain;
                  end
               end
               if (rd_idx_ff == CNT_W'(TABLE_ENTRIES)) begin
                  pend_in  = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  rd_en       = 1'b1;
                  proc_idx_in = rd_idx_ff[IDX_W-1:0];
                  pend_in     = 1'b1;
                  rd_idx_in   = rd_idx_ff + CNT_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{event_id: req_ff.timer_id, event_res: RES_DONE, last: 1'b1};
               case (req_ff.action)
                  ACT_TICK: begin
                     hold_valid_in = 1'b0;
                     if (hold_valid_ff) begin
                        rsp_in = '{event_id: hold_id_ff, event_res: hold_res_ff, last: 1'b1};
                     end else begin
                        rsp_in = '{event_id: 32'd0, event_res: RES_DONE, last: 1'b1};
                     end
                  end
                  ACT_ADD: begin
                     if (found_ff || free_found) begin
                        wr_en              = 1'b1;
                        wr_idx             = tgt_idx;
                        wr_data            = '{ident: req_ff.timer_id, period: delay_eff,
                                               remain: delay_eff};
                        valid_in[tgt_idx]  = 1'b1;
                        cancel_in[tgt_idx] = 1'b0;
                     end else begin
                        rsp_in.event_res = RES_FULL;
                     end
                  end
                  ACT_REFRESH: begin
                     if (!found_ff) begin
                        rsp_in.event_res = RES_NOT_FOUND;
                     end else if (match_period_ff > match_remain_ff) begin
                        wr_en   = 1'b1;
                        wr_idx  = match_idx_ff;
                        wr_data = '{ident: req_ff.timer_id, period: match_period_ff,
                                    remain: match_period_ff};
                     end
                  end
                  ACT_CANCEL: begin
                     if (found_ff) begin
                        cancel_in[match_idx_ff] = 1'b1;
                     end else begin
                        rsp_in.event_res = RES_NOT_FOUND;
                     end
                  end
                  default: begin
                     rsp_in.event_res = RES_DONE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slots_ff      <= SLOTS_RESET;
         rd_idx_ff     <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
         exp_cnt_ff    <= '0;
         valid_ff      <= '0;
         cancel_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slots_ff      <= slots_in;
         rd_idx_ff     <= rd_idx_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         hold_valid_ff <= hold_valid_in;
         exp_cnt_ff    <= exp_cnt_in;
         valid_ff      <= valid_in;
         cancel_ff     <= cancel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      proc_idx_ff     <= proc_idx_in;
      match_idx_ff    <= match_idx_in;
      match_period_ff <= match_period_in;
      match_remain_ff <= match_remain_in;
      hold_id_ff      <= hold_id_in;
      hold_res_ff     <= hold_res_in;
      rsp_ff          <= rsp_in;
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/twtt_checker.sv =====
`include "assert_macros.svh"

module twtt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input twtt_pkg::rsp_type rsp_data
);
   import twtt_pkg::*;

   `ASSERT_RST(a_rsp_idle_after_reset, reset |=> !rsp_valid, "result valid after reset")

   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   `ASSERT_CLK(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "second request taken while busy")

   `ASSERT_CLK(a_res_range, rsp_valid |-> rsp_data.event_res <= RES_FULL, "result code out of range")

   `ASSERT_CLK(a_error_is_last, rsp_valid && (rsp_data.event_res == RES_NOT_FOUND || rsp_data.event_res == RES_FULL) |-> rsp_data.last, "error result not marked last")

endmodule

bind timing_wheel_timer_table_top twtt_checker u_twtt_checker (.*);
